### rtl/core/tmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmt_pkg: shared types and constants of the tournament min tree
// Leaf count, tree depth, the never time code and the beat structs used
// between the top level and the node store.
// ----------------------------------------------------------------------------
package tmt_pkg;

    // Tree geometry: the leaf count is a power of two.
    localparam int LEAVES = 256;
    localparam int LEAF_W = $clog2(LEAVES);
    localparam int LEVELS = LEAF_W;
    localparam int LVL_W  = $clog2(LEVELS + 1);
    localparam int POS_W  = LEAF_W + 1;
    localparam int TIME_W = 64;

    // All ones marks a leaf that has nothing scheduled.
    localparam logic [TIME_W-1:0] TIME_NEVER = '1;

    // Input beat.
    typedef struct packed {
        logic [LEAF_W-1:0] leaf_index;
        logic [TIME_W-1:0] new_time;
        logic              batch_last;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic [LEAF_W-1:0] min_index;
        logic [TIME_W-1:0] min_time;
    } t_out;

    // Winner held by an internal node: leaf index and its time.
    typedef struct packed {
        logic [LEAF_W-1:0] idx;
        logic [TIME_W-1:0] tval;
    } t_node;

    // Node store write request.
    typedef struct packed {
        logic              en;
        logic [LEAF_W-1:0] addr;
        t_node             data;
    } t_node_wr;

    // Node store read request.
    typedef struct packed {
        logic              en;
        logic [LEAF_W-1:0] addr;
    } t_node_rd;

endpackage
`default_nettype wire

### rtl/core/tournament_min_tree_update.sv
`timescale 1ns / 1ps
`default_nettype none
// A batch-end beat's result is on o_result, marked by o_strobe, once its walk reaches the root.
// No item is taken while busy, which stays high as the walk visits the 8 levels, one node each.
// The rate is set by the node store read-compare-write, one tree level per cycle.
// Reset is synchronous; it clears leaf and node valid bits, so every leaf reads as never at once.
// The receiver cannot stall: the result beat lasts exactly one cycle.
// ----------------------------------------------------------------------------
// tournament_min_tree_update: winner tree over next-event times
// Each beat writes one leaf time and walks the leaf's path to the root,
// one node per cycle. A batch-end beat reports the overall minimum.
// ----------------------------------------------------------------------------
module tournament_min_tree_update (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire tmt_pkg::t_in  i_item,
    output logic               o_strobe,
    output tmt_pkg::t_out      o_result
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    t_state r_state;
    logic [tmt_pkg::LVL_W-1:0]  r_level;
    logic [tmt_pkg::POS_W-1:0]  r_pos;
    tmt_pkg::t_node             r_cur;
    logic                       r_last;
    logic [tmt_pkg::LEAF_W-1:0] r_dflt_idx;
    logic                       r_strobe;
    tmt_pkg::t_out              r_result;

    // Leaf time store with valid bits.
    logic [tmt_pkg::TIME_W-1:0] r_leaf_mem [tmt_pkg::LEAVES];
    logic [tmt_pkg::LEAVES-1:0] r_leaf_vld;
    logic [tmt_pkg::TIME_W-1:0] r_lf_rd;
    logic                       r_lf_rd_vld;

    logic                       accept;
    logic [tmt_pkg::LEAF_W-1:0] sib_leaf;
    logic [tmt_pkg::LEAF_W-1:0] node_n;
    logic                       at_root;
    tmt_pkg::t_node             sib;
    tmt_pkg::t_node             win;
    tmt_pkg::t_node_wr          nd_wr;
    tmt_pkg::t_node_rd          nd_rd;
    tmt_pkg::t_node             nd_rd_data;
    logic                       nd_rd_vld;

    assign accept   = start && !busy;
    assign sib_leaf = i_item.leaf_index ^ tmt_pkg::LEAF_W'(1);
    assign node_n   = r_pos[tmt_pkg::POS_W-1:1];
    assign at_root  = (r_level == tmt_pkg::LVL_W'(tmt_pkg::LEVELS));

    // Leaf write on accept, with the sibling leaf read at the same time.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_leaf_mem[i_item.leaf_index] <= i_item.new_time;
        end
        r_lf_rd <= r_leaf_mem[sib_leaf];
    end

    // Leaf valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leaf_vld  <= '0;
            r_lf_rd_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_leaf_vld[i_item.leaf_index] <= 1'b1;
            end
            r_lf_rd_vld <= r_leaf_vld[sib_leaf];
        end
    end

    // Sibling winner: a leaf on the first level, a stored node above it.
    // A node never written holds the lowest leaf of its subtree at time never.
    always_comb begin
        if (r_level == tmt_pkg::LVL_W'(1)) begin
            sib.idx  = r_cur.idx ^ tmt_pkg::LEAF_W'(1);
            sib.tval = r_lf_rd_vld ? r_lf_rd : tmt_pkg::TIME_NEVER;
        end else begin
            sib.idx  = nd_rd_vld ? nd_rd_data.idx : r_dflt_idx;
            sib.tval = nd_rd_vld ? nd_rd_data.tval : tmt_pkg::TIME_NEVER;
        end
    end

    // Compare at this node; on a tie the left child wins.
    always_comb begin
        if (r_pos[0]) begin
            win = (r_cur.tval < sib.tval) ? r_cur : sib;
        end else begin
            win = (sib.tval < r_cur.tval) ? sib : r_cur;
        end
    end

    // Write the node's winner and fetch the sibling of that node.
    always_comb begin
        nd_wr.en   = (r_state == S_WALK);
        nd_wr.addr = node_n;
        nd_wr.data = win;
        nd_rd.en   = (r_state == S_WALK) && !at_root;
        nd_rd.addr = node_n ^ tmt_pkg::LEAF_W'(1);
    end

    tmt_node_mem u_node_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (nd_wr),
        .i_rd      (nd_rd),
        .o_rd_data (nd_rd_data),
        .o_rd_vld  (nd_rd_vld)
    );

    // Walk sequencer and registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_level  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state    <= S_WALK;
                        r_level    <= tmt_pkg::LVL_W'(1);
                        r_pos      <= {1'b1, i_item.leaf_index};
                        r_cur.idx  <= i_item.leaf_index;
                        r_cur.tval <= i_item.new_time;
                        r_last     <= i_item.batch_last;
                    end
                end
                S_WALK: begin
                    r_cur      <= win;
                    r_pos      <= {1'b0, node_n};
                    r_level    <= r_level + tmt_pkg::LVL_W'(1);
                    r_dflt_idx <= tmt_pkg::LEAF_W'(nd_rd.addr << r_level);
                    if (at_root) begin
                        r_state            <= S_IDLE;
                        r_strobe           <= r_last;
                        r_result.min_index <= win.idx;
                        r_result.min_time  <= win.tval;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state == S_WALK);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

`ifndef ASSERT_OFF
    // A result beat appears only as the walk finishes.
    a_strobe_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $fell(busy))
        else $error("result beat outside the end of a walk");

    // The level counter stays on the tree while walking.
    a_level_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> ((r_level >= tmt_pkg::LVL_W'(1)) &&
                  (r_level <= tmt_pkg::LVL_W'(tmt_pkg::LEVELS))))
        else $error("walk level out of range");

    // An accepted beat starts a walk on the next cycle.
    a_accept_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && (r_level == tmt_pkg::LVL_W'(1))))
        else $error("accepted beat did not start a walk");
`endif

endmodule
`default_nettype wire

### rtl/core/tmt_node_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmt_node_mem: winner store of the internal tree nodes
// One write port and one registered read port over the nodes in heap order.
// A valid bit per node tells the reader whether the entry was ever written.
// ----------------------------------------------------------------------------
module tmt_node_mem (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tmt_pkg::t_node_wr i_wr,
    input  wire tmt_pkg::t_node_rd i_rd,
    output tmt_pkg::t_node         o_rd_data,
    output logic                   o_rd_vld
);

    // Node storage; node 0 does not exist in heap order.
    tmt_pkg::t_node r_mem [1:tmt_pkg::LEAVES-1];
    logic [tmt_pkg::LEAVES-1:1] r_vld;
    tmt_pkg::t_node r_rd_data;
    logic r_rd_vld;

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    // Valid bits, cleared by reset, and the valid flag of the read beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_rd_vld  = r_rd_vld;

`ifndef ASSERT_OFF
    // The walk never reads the node it writes in the same cycle.
    a_no_rw_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rd.en && i_wr.en) |-> (i_rd.addr != i_wr.addr))
        else $error("node store read and write hit the same entry");

    // Node zero is not part of the tree.
    a_no_node0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_wr.en || (i_wr.addr != '0)) && (!i_rd.en || (i_rd.addr != '0)))
        else $error("node store access to node zero");
`endif

endmodule
`default_nettype wire

### tb/tb_tournament_min_tree_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tournament_min_tree_update: self-checking bench for the min winner tree
// Drives leaf time updates through the start/busy handshake, keeps its own
// winner tree of the schedule, and checks every batch-end result against
// the minimum it predicts (lower leaf index on ties). Directed cases come
// first, then random batches under three sender idle settings.
// ----------------------------------------------------------------------------
module tb_tournament_min_tree_update;

    import tmt_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_in   i_item;
    logic  o_strobe;
    t_out  o_result;

    // Predicted schedule: one time per leaf and one winner per internal node.
    logic [TIME_W-1:0] sched_time  [LEAVES];
    logic [LEAF_W-1:0] node_winner [1:LEAVES-1];

    // Minima still to come from the block, oldest first.
    t_out pending_minima [$];

    int mismatch_count;
    int idle_cycles;
    int sender_idle_pct;

    tournament_min_tree_update i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // Clock: 12 ns period.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Winner of a tree position: a node's stored winner or the leaf itself.
    function automatic logic [LEAF_W-1:0] subtree_winner(int p);
        if (p >= LEAVES) begin
            return LEAF_W'(p - LEAVES);
        end
        return node_winner[p];
    endfunction

    // One comparison: the right child wins only when strictly earlier.
    function automatic void eval_node(int n);
        logic [LEAF_W-1:0] l;
        logic [LEAF_W-1:0] r;
        l = subtree_winner(2 * n);
        r = subtree_winner(2 * n + 1);
        node_winner[n] = (sched_time[r] < sched_time[l]) ? r : l;
    endfunction

    function automatic void clear_schedule();
        for (int i = 0; i < LEAVES; i++) begin
            sched_time[i] = TIME_NEVER;
        end
        for (int n = LEAVES - 1; n >= 1; n--) begin
            eval_node(n);
        end
    endfunction

    // Apply one accepted beat and queue the minimum if it ends a batch.
    function automatic void track_update(t_in b);
        int   n;
        t_out m;
        sched_time[b.leaf_index] = b.new_time;
        n = (int'(b.leaf_index) + LEAVES) >> 1;
        while (n >= 1) begin
            eval_node(n);
            n = n >> 1;
        end
        if (b.batch_last) begin
            m.min_index = node_winner[1];
            m.min_time  = sched_time[node_winner[1]];
            pending_minima.push_back(m);
        end
    endfunction

    function automatic t_in make_beat(int leaf, logic [TIME_W-1:0] t, bit last);
        t_in b;
        b.leaf_index = LEAF_W'(leaf);
        b.new_time   = t;
        b.batch_last = last;
        return b;
    endfunction

    // Send one beat; called and returning at a rising edge. Start stays high
    // after acceptance unless the sender decides to idle.
    task automatic send_beat(t_in b);
        start  <= 1'b1;
        i_item <= b;
        do begin
            @(posedge i_clk);
        end while (busy);
        track_update(b);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    endtask

    // Result checker: each strobed beat against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            if (pending_minima.size() == 0) begin
                $display("%0t ERROR unexpected result: min_index %0d min_time %h",
                         $time, o_result.min_index, o_result.min_time);
                mismatch_count++;
            end else begin
                want = pending_minima.pop_front();
                if (o_result.min_index !== want.min_index) begin
                    $display("%0t ERROR min_index expected %0d actual %0d",
                             $time, want.min_index, o_result.min_index);
                    mismatch_count++;
                end
                if (o_result.min_time !== want.min_time) begin
                    $display("%0t ERROR min_time expected %h actual %h",
                             $time, want.min_time, o_result.min_time);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: cycles in which no beat moves in either direction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL tournament_min_tree_update");
                $finish;
            end
        end
    end

    // Empty tree and a write of never into an empty tree.
    task automatic test_nothing_scheduled();
        send_beat(make_beat(0, TIME_NEVER, 1'b1));
        send_beat(make_beat(LEAVES - 1, TIME_NEVER, 1'b1));
    endtask

    // Extremes of the index and time fields.
    task automatic test_field_extremes();
        send_beat(make_beat(LEAVES - 1, '0, 1'b1));
        send_beat(make_beat(0, TIME_NEVER - 1, 1'b1));
        send_beat(make_beat(LEAVES - 1, TIME_NEVER, 1'b1));
        send_beat(make_beat(0, TIME_NEVER, 1'b1));
        send_beat(make_beat(LEAVES / 2, TIME_NEVER - 1, 1'b1));
        send_beat(make_beat(LEAVES / 2, TIME_NEVER, 1'b1));
    endtask

    // Equal times: the lower index must win whatever the write order.
    task automatic test_tie_break();
        send_beat(make_beat(200, 64'd5, 1'b0));
        send_beat(make_beat(100, 64'd5, 1'b0));
        send_beat(make_beat(50, 64'd7, 1'b1));
        send_beat(make_beat(100, TIME_NEVER, 1'b1));
        send_beat(make_beat(0, '0, 1'b0));
        send_beat(make_beat(LEAVES - 1, '0, 1'b1));
        send_beat(make_beat(0, TIME_NEVER, 1'b1));
    endtask

    // Updates without a batch end produce nothing until the batch closes.
    task automatic test_batch_without_end();
        send_beat(make_beat(8'h55, 64'h5555_5555_5555_5555, 1'b0));
        send_beat(make_beat(8'hAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
        send_beat(make_beat(8'h0F, 64'h0F0F_0F0F_0F0F_0F0F, 1'b0));
        send_beat(make_beat(8'hF0, 64'hF0F0_F0F0_F0F0_F0F0, 1'b1));
    endtask

    // Random time: often small values so ties and overwrites are common.
    function automatic logic [TIME_W-1:0] pick_time();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40) return TIME_W'($urandom_range(63));
        if (sel < 60) return {$urandom(), $urandom()};
        if (sel < 75) return TIME_NEVER;
        if (sel < 85) return TIME_NEVER - TIME_W'($urandom_range(3));
        return {32'd0, $urandom()};
    endfunction

    // Random batches; now and then the current winner is retired so the
    // minimum moves to another subtree.
    task automatic test_random_traffic(int beat_goal, int idle_pct);
        int sent;
        int len;
        int leaf;
        sent = 0;
        sender_idle_pct = idle_pct;
        while (sent < beat_goal) begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                if (j == 0 && $urandom_range(9) < 3) begin
                    leaf = node_winner[1];
                    send_beat(make_beat(leaf, TIME_NEVER, j == len - 1));
                end else begin
                    leaf = ($urandom_range(1)) ? $urandom_range(15)
                                               : $urandom_range(LEAVES - 1);
                    send_beat(make_beat(leaf, pick_time(), j == len - 1));
                end
                sent++;
            end
        end
    endtask

    initial begin
        mismatch_count  = 0;
        sender_idle_pct = 33;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        clear_schedule();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_nothing_scheduled();
        test_field_extremes();
        test_tie_break();
        test_batch_without_end();
        test_random_traffic(480, 33);
        test_random_traffic(480, 76);
        test_random_traffic(470, 0);
        start <= 1'b0;

        // Drain: wait for every predicted minimum, then idle before the verdict.
        while (pending_minima.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS tournament_min_tree_update");
        end else begin
            $display("FAIL tournament_min_tree_update");
        end
        $finish;
    end

endmodule
